// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the sentence parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i while rst_ni is high.
`define NGFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds on a rising edge of clk_i while rst_ni is high.
`define NGFE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/ngfe_pkg.sv =====
// Types and constants shared by the sentence parser modules.
package ngfe_pkg;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;
  localparam int CMD_CNT_W = 3;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_G1,
    PH_P,
    PH_G2,
    PH_G3,
    PH_ANY,
    PH_SKIP_A,
    PH_SKIP_B,
    PH_CAP1,
    PH_SKIP_C,
    PH_CAP2,
    PH_SKIP_D,
    PH_FIX
  } parse_phase_e;

  typedef enum logic [0:0] {
    BK_EXEC,
    BK_EMIT
  } back_state_e;

  typedef enum logic [2:0] {
    CMD_CLR1,
    CMD_CAP1,
    CMD_CLR2,
    CMD_CAP2,
    CMD_FIX
  } cmd_op_e;

  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_FIX    = 2'd2
  } item_kind_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] char_value;
    logic       truncated;
    logic       last;
  } item_t;

endpackage

// ===== sv/ngfe_byte_if.sv =====
// Channel that carries one received serial word.
interface ngfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/ngfe_item_if.sv =====
// Channel that carries one reported result word.
interface ngfe_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] char_value;
  logic       truncated;
  logic       last;

  modport source (output valid, output item_kind, output char_value, output truncated,
                  output last, input ready);
  modport sink (input valid, input item_kind, input char_value, input truncated,
                input last, output ready);
endinterface

// ===== sv/ngfe_cmd_fifo.sv =====
// Short command queue between the sentence front end and the field back end.
module ngfe_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ngfe_pkg::cmd_req_t  push_i,
  input  logic                pop_i,
  output ngfe_pkg::cmd_t      head_o,
  output ngfe_pkg::fifo_stat_t stat_o
);

  ngfe_pkg::cmd_t                   slots_q [ngfe_pkg::CMD_DEPTH];
  logic [ngfe_pkg::CMD_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ngfe_pkg::CMD_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ngfe_pkg::CMD_CNT_W-1:0]   count_q, count_d;
  logic                             do_push;
  logic                             do_pop;

  assign stat_o.full  = (count_q == ngfe_pkg::CMD_CNT_W'(ngfe_pkg::CMD_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = slots_q[rd_ptr_q];

  assign do_push = push_i.valid && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

// ===== sv/ngfe_front.sv =====
// Sentence front end: tracks the header and field position and issues commands.
module ngfe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ngfe_byte_if.sink            rx_i,
  input  ngfe_pkg::fifo_stat_t stat_i,
  output ngfe_pkg::cmd_req_t   push_o
);

  ngfe_pkg::parse_phase_e phase_q, phase_d;
  logic                   accept;
  logic                   comma;
  logic [7:0]             c;

  assign rx_i.ready = !stat_i.full;
  assign accept     = rx_i.valid && rx_i.ready;
  assign c          = rx_i.rx_byte;
  assign comma      = (c == ngfe_pkg::CHAR_COMMA);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        ngfe_pkg::PH_IDLE:   if (c == ngfe_pkg::CHAR_DOLLAR) phase_d = ngfe_pkg::PH_G1;
        ngfe_pkg::PH_G1:     phase_d = (c == ngfe_pkg::CHAR_G) ? ngfe_pkg::PH_P
                                                                : ngfe_pkg::PH_IDLE;
        ngfe_pkg::PH_P:      phase_d = (c == ngfe_pkg::CHAR_P) ? ngfe_pkg::PH_G2
                                                                : ngfe_pkg::PH_IDLE;
        ngfe_pkg::PH_G2:     phase_d = (c == ngfe_pkg::CHAR_G) ? ngfe_pkg::PH_G3
                                                                : ngfe_pkg::PH_IDLE;
        ngfe_pkg::PH_G3:     phase_d = (c == ngfe_pkg::CHAR_G) ? ngfe_pkg::PH_ANY
                                                                : ngfe_pkg::PH_IDLE;
        ngfe_pkg::PH_ANY:    phase_d = ngfe_pkg::PH_SKIP_A;
        ngfe_pkg::PH_SKIP_A: if (comma) phase_d = ngfe_pkg::PH_SKIP_B;
        ngfe_pkg::PH_SKIP_B: if (comma) phase_d = ngfe_pkg::PH_CAP1;
        ngfe_pkg::PH_CAP1:   if (comma) phase_d = ngfe_pkg::PH_SKIP_C;
        ngfe_pkg::PH_SKIP_C: if (comma) phase_d = ngfe_pkg::PH_CAP2;
        ngfe_pkg::PH_CAP2:   if (comma) phase_d = ngfe_pkg::PH_SKIP_D;
        ngfe_pkg::PH_SKIP_D: if (comma) phase_d = ngfe_pkg::PH_FIX;
        ngfe_pkg::PH_FIX:    phase_d = ngfe_pkg::PH_IDLE;
        default:             phase_d = ngfe_pkg::PH_IDLE;
      endcase
    end
  end

  // Command issued for the accepted word, if any.
  always_comb begin
    push_o.valid    = 1'b0;
    push_o.cmd.op   = ngfe_pkg::CMD_FIX;
    push_o.cmd.data = c;
    case (phase_q)
      ngfe_pkg::PH_SKIP_B: begin
        push_o.valid  = accept && comma;
        push_o.cmd.op = ngfe_pkg::CMD_CLR1;
      end
      ngfe_pkg::PH_CAP1: begin
        push_o.valid  = accept && !comma;
        push_o.cmd.op = ngfe_pkg::CMD_CAP1;
      end
      ngfe_pkg::PH_SKIP_C: begin
        push_o.valid  = accept && comma;
        push_o.cmd.op = ngfe_pkg::CMD_CLR2;
      end
      ngfe_pkg::PH_CAP2: begin
        push_o.valid  = accept && !comma;
        push_o.cmd.op = ngfe_pkg::CMD_CAP2;
      end
      ngfe_pkg::PH_FIX: begin
        push_o.valid  = accept;
        push_o.cmd.op = ngfe_pkg::CMD_FIX;
      end
      default: begin
        push_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ngfe_pkg::PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== sv/ngfe_back.sv =====
// Field back end: holds the captured fields and plays out the result run.
module ngfe_back #(
  parameter int MAX_FIELD_LEN = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ngfe_pkg::cmd_t       head_i,
  input  ngfe_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  ngfe_item_if.source          res_o
);

  localparam int LEN_W = $clog2(MAX_FIELD_LEN + 1);
  localparam int IDX_W = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_FIELD_LEN);

  ngfe_pkg::back_state_e state_q, state_d;
  ngfe_pkg::item_kind_e  em_kind_q;
  logic [LEN_W-1:0]      em_idx_q;
  logic [LEN_W-1:0]      len1_q, len2_q;
  logic                  ovf1_q, ovf2_q;
  logic [7:0]            fix_q;
  logic [7:0]            mem1 [MAX_FIELD_LEN];
  logic [7:0]            mem2 [MAX_FIELD_LEN];
  logic                  rd_vld_q, out_vld_q;
  ngfe_pkg::item_t       rd_q, out_q;

  logic                  out_free, rd_free;
  logic                  emitting, on_field;
  logic [LEN_W-1:0]      cur_len;
  logic                  has_more;
  logic                  issue_mem, issue_fix;
  logic                  start_run;

  assign out_free = !out_vld_q || res_o.ready;
  assign rd_free  = !rd_vld_q || out_free;
  assign emitting = (state_q == ngfe_pkg::BK_EMIT);
  assign on_field = (em_kind_q != ngfe_pkg::KIND_FIX);
  assign cur_len  = (em_kind_q == ngfe_pkg::KIND_FIRST) ? len1_q : len2_q;
  assign has_more = (em_idx_q < cur_len);

  // Control outputs of the back end.
  always_comb begin
    pop_o     = (state_q == ngfe_pkg::BK_EXEC) && !stat_i.empty;
    issue_mem = emitting && on_field && has_more && rd_free;
    issue_fix = emitting && !on_field && rd_free;
    start_run = pop_o && (head_i.op == ngfe_pkg::CMD_FIX);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ngfe_pkg::BK_EXEC: if (start_run) state_d = ngfe_pkg::BK_EMIT;
      ngfe_pkg::BK_EMIT: if (issue_fix) state_d = ngfe_pkg::BK_EXEC;
      default:           state_d = ngfe_pkg::BK_EXEC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ngfe_pkg::BK_EXEC;
      em_kind_q <= ngfe_pkg::KIND_FIRST;
      em_idx_q  <= '0;
      len1_q    <= '0;
      len2_q    <= '0;
      ovf1_q    <= 1'b0;
      ovf2_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        case (head_i.op)
          ngfe_pkg::CMD_CLR1: begin
            len1_q <= '0;
            ovf1_q <= 1'b0;
          end
          ngfe_pkg::CMD_CAP1: begin
            if (len1_q < MaxLen) len1_q <= len1_q + 1'b1;
            else ovf1_q <= 1'b1;
          end
          ngfe_pkg::CMD_CLR2: begin
            len2_q <= '0;
            ovf2_q <= 1'b0;
          end
          ngfe_pkg::CMD_CAP2: begin
            if (len2_q < MaxLen) len2_q <= len2_q + 1'b1;
            else ovf2_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (start_run) begin
        em_kind_q <= ngfe_pkg::KIND_FIRST;
        em_idx_q  <= '0;
      end else if (emitting && on_field) begin
        if (issue_mem) begin
          em_idx_q <= em_idx_q + 1'b1;
        end else if (!has_more) begin
          // Field played out: move to the next kind of the run.
          em_kind_q <= (em_kind_q == ngfe_pkg::KIND_FIRST) ? ngfe_pkg::KIND_SECOND
                                                           : ngfe_pkg::KIND_FIX;
          em_idx_q  <= '0;
        end
      end
      if (rd_free) rd_vld_q <= issue_mem || issue_fix;
      if (out_free) out_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.op == ngfe_pkg::CMD_CAP1) && (len1_q < MaxLen)) begin
      mem1[len1_q[IDX_W-1:0]] <= head_i.data;
    end
    if (pop_o && (head_i.op == ngfe_pkg::CMD_CAP2) && (len2_q < MaxLen)) begin
      mem2[len2_q[IDX_W-1:0]] <= head_i.data;
    end
    if (start_run) fix_q <= head_i.data;
    if (issue_mem) begin
      rd_q.kind       <= em_kind_q;
      rd_q.char_value <= (em_kind_q == ngfe_pkg::KIND_FIRST) ? mem1[em_idx_q[IDX_W-1:0]]
                                                             : mem2[em_idx_q[IDX_W-1:0]];
      rd_q.truncated  <= (em_kind_q == ngfe_pkg::KIND_FIRST) ? ovf1_q : ovf2_q;
      rd_q.last       <= 1'b0;
    end else if (issue_fix) begin
      rd_q.kind       <= ngfe_pkg::KIND_FIX;
      rd_q.char_value <= fix_q;
      rd_q.truncated  <= 1'b0;
      rd_q.last       <= 1'b1;
    end
    if (out_free && rd_vld_q) out_q <= rd_q;
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.item_kind  = out_q.kind;
  assign res_o.char_value = out_q.char_value;
  assign res_o.truncated  = out_q.truncated;
  assign res_o.last       = out_q.last;

endmodule

// ===== sv/nmea_gga_field_extractor_top.sv =====
// Top level of the GGA sentence field extractor.
// The block takes one received serial word per cycle while the queue is not full and
// follows a "$GPGGA" sentence, with any sixth header character; when the fix character
// arrives it reports the captured latitude characters, then the longitude characters,
// then the fix character, marked last. A front end classifies each word combinationally
// and posts capture and report commands to a four-entry queue; a back end keeps the two
// field buffers and plays out the run, one result per cycle while the sink takes them,
// pausing between fields. While a run of up to 2 * MAX_FIELD_LEN + 1 results plays out
// the back end takes no commands, so input words keep flowing until the queue holds four
// commands and then stall until the run is done. No clearing pass is needed after reset.
`include "assert_macros.svh"

module nmea_gga_field_extractor_top #(
  parameter int MAX_FIELD_LEN = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  ngfe_byte_if.sink   rx_i,
  ngfe_item_if.source res_o
);

  ngfe_pkg::cmd_req_t   cmd_push;
  ngfe_pkg::cmd_t       cmd_head;
  ngfe_pkg::fifo_stat_t fifo_stat;
  logic                 cmd_pop;
  logic                 last_word_ok;

  ngfe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .stat_i (fifo_stat),
    .push_o (cmd_push)
  );

  ngfe_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .pop_i  (cmd_pop),
    .head_o (cmd_head),
    .stat_o (fifo_stat)
  );

  ngfe_back #(
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (cmd_head),
    .stat_i (fifo_stat),
    .pop_o  (cmd_pop),
    .res_o  (res_o)
  );

  assign last_word_ok = (res_o.item_kind == ngfe_pkg::KIND_FIX) && !res_o.truncated;

  // A command is never offered to a full queue, so none is lost.
  `NGFE_ASSERT_NEVER(a_no_push_full, cmd_push.valid && fifo_stat.full, "push into full queue")
  // A command pushed without a pop leaves the queue non-empty.
  `NGFE_ASSERT(a_push_lands, (cmd_push.valid && !cmd_pop) |=> !fifo_stat.empty, "push lost")
  // The word that ends a run is the fix character and never carries a truncation mark.
  `NGFE_ASSERT(a_last_is_fix, (res_o.valid && res_o.last) |-> last_word_ok, "bad last word")

endmodule
